### sv/rba_pkg.sv
// Shared types and constants of the rotated blit address generator.
package rba_pkg;

  localparam int FRAC_BITS  = 10;
  localparam int ACC_W      = 24;
  localparam int COL_W      = 13;
  localparam int STEP_W     = 12;
  localparam int STRIDE_W   = 16;
  localparam int ADDR_W     = 32;
  localparam int OFS_W      = ACC_W - FRAC_BITS;
  localparam int IN_COL_W   = 12;
  localparam int FUNC_W     = 2;
  localparam int MODE_W     = 2;
  localparam int PADDR_W    = 5;
  localparam int PDATA_W    = 32;
  localparam int REG_IDX_W  = 3;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_SPAN  = 2'd1,
    FUNC_PIXEL = 2'd2,
    FUNC_EOR   = 2'd3
  } func_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_STEP_HX    = 3'd0,
    REG_STEP_HY    = 3'd1,
    REG_STEP_VX    = 3'd2,
    REG_STEP_VY    = 3'd3,
    REG_SRC_BASE   = 3'd4,
    REG_SRC_STRIDE = 3'd5,
    REG_DST_STRIDE = 3'd6,
    REG_MODE       = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [STEP_W-1:0] step_hx;
    logic signed [STEP_W-1:0] step_hy;
    logic signed [STEP_W-1:0] step_vx;
    logic signed [STEP_W-1:0] step_vy;
    logic [ADDR_W-1:0]        src_base;
    logic [STRIDE_W-1:0]      src_stride;
    logic [STRIDE_W-1:0]      dst_stride;
    logic [MODE_W-1:0]        mode;
  } cfg_t;

  // Walker state captured for one pixel.
  typedef struct packed {
    logic signed [ACC_W-1:0] row_x;
    logic signed [ACC_W-1:0] row_y;
    logic signed [ACC_W-1:0] col_x;
    logic signed [ACC_W-1:0] col_y;
    logic [ADDR_W-1:0]       row_off;
    logic [COL_W-1:0]        col;
  } pix_t;

endpackage

### sv/rba_cfg.sv
// Configuration register file behind the APB-style port.
module rba_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rba_pkg::PADDR_W-1:0] paddr,
  input  logic [rba_pkg::PDATA_W-1:0] pwdata,
  output logic [rba_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output rba_pkg::cfg_t               cfg_o
);
  import rba_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_STEP_HX:    cfg_d.step_hx    = pwdata[STEP_W-1:0];
        REG_STEP_HY:    cfg_d.step_hy    = pwdata[STEP_W-1:0];
        REG_STEP_VX:    cfg_d.step_vx    = pwdata[STEP_W-1:0];
        REG_STEP_VY:    cfg_d.step_vy    = pwdata[STEP_W-1:0];
        REG_SRC_BASE:   cfg_d.src_base   = pwdata[ADDR_W-1:0];
        REG_SRC_STRIDE: cfg_d.src_stride = pwdata[STRIDE_W-1:0];
        REG_DST_STRIDE: cfg_d.dst_stride = pwdata[STRIDE_W-1:0];
        REG_MODE:       cfg_d.mode       = pwdata[MODE_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_STEP_HX:    prdata = PDATA_W'(cfg_q.step_hx);
      REG_STEP_HY:    prdata = PDATA_W'(cfg_q.step_hy);
      REG_STEP_VX:    prdata = PDATA_W'(cfg_q.step_vx);
      REG_STEP_VY:    prdata = PDATA_W'(cfg_q.step_vy);
      REG_SRC_BASE:   prdata = PDATA_W'(cfg_q.src_base);
      REG_SRC_STRIDE: prdata = PDATA_W'(cfg_q.src_stride);
      REG_DST_STRIDE: prdata = PDATA_W'(cfg_q.dst_stride);
      REG_MODE:       prdata = PDATA_W'(cfg_q.mode);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q            <= '0;
      cfg_q.step_hx    <= STEP_W'(1 << FRAC_BITS);
      cfg_q.step_vy    <= STEP_W'(1 << FRAC_BITS);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### sv/rba_dda.sv
// DDA walker state and the pixel input register.
module rba_dda (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rba_pkg::cfg_t                cfg_i,
  input  logic                         accept_i,
  input  logic [rba_pkg::FUNC_W-1:0]   func_i,
  input  logic [rba_pkg::IN_COL_W-1:0] column_i,
  input  logic                         adv_i,
  output logic                         pix_valid_o,
  output rba_pkg::pix_t                pix_o
);
  import rba_pkg::*;

  logic signed [ACC_W-1:0] row_x_q, row_x_d, row_y_q, row_y_d;
  logic signed [ACC_W-1:0] col_x_q, col_x_d, col_y_q, col_y_d;
  logic [ADDR_W-1:0]       row_off_q, row_off_d;
  logic [COL_W-1:0]        col_q, col_d;
  logic                    pix_valid_q, pix_valid_d;
  pix_t                    pix_q;
  func_e                   func;

  logic signed [IN_COL_W:0]          col_s;
  logic signed [IN_COL_W+STEP_W:0]   span_x, span_y;
  logic [ADDR_W-1:0]                 row_step;

  assign func     = func_e'(func_i);
  assign col_s    = $signed({1'b0, column_i});
  assign span_x   = col_s * cfg_i.step_hx;
  assign span_y   = col_s * cfg_i.step_hy;
  assign row_step = cfg_i.mode[1] ? ADDR_W'({cfg_i.dst_stride, 1'b0})
                                  : ADDR_W'(cfg_i.dst_stride);

  always_comb begin
    row_x_d   = row_x_q;
    row_y_d   = row_y_q;
    col_x_d   = col_x_q;
    col_y_d   = col_y_q;
    row_off_d = row_off_q;
    col_d     = col_q;
    if (accept_i) begin
      unique case (func)
        FUNC_CLEAR: begin
          row_x_d   = '0;
          row_y_d   = '0;
          col_x_d   = '0;
          col_y_d   = '0;
          row_off_d = '0;
          col_d     = '0;
        end
        FUNC_SPAN: begin
          col_x_d = span_x[ACC_W-1:0];
          col_y_d = span_y[ACC_W-1:0];
          col_d   = COL_W'(column_i);
        end
        FUNC_PIXEL: begin
          col_x_d = col_x_q + ACC_W'(cfg_i.step_hx);
          col_y_d = col_y_q + ACC_W'(cfg_i.step_hy);
          col_d   = col_q + COL_W'(1);
        end
        FUNC_EOR: begin
          row_x_d   = row_x_q + ACC_W'(cfg_i.step_vx);
          row_y_d   = row_y_q + ACC_W'(cfg_i.step_vy);
          row_off_d = row_off_q + row_step;
          col_x_d   = '0;
          col_y_d   = '0;
          col_d     = '0;
        end
        default: ;
      endcase
    end
  end

  // A transfer only lands when the pixel register is empty or moving on.
  always_comb begin
    if (accept_i) pix_valid_d = (func == FUNC_PIXEL);
    else if (adv_i) pix_valid_d = 1'b0;
    else pix_valid_d = pix_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_x_q     <= '0;
      row_y_q     <= '0;
      col_x_q     <= '0;
      col_y_q     <= '0;
      row_off_q   <= '0;
      col_q       <= '0;
      pix_valid_q <= 1'b0;
    end else begin
      row_x_q     <= row_x_d;
      row_y_q     <= row_y_d;
      col_x_q     <= col_x_d;
      col_y_q     <= col_y_d;
      row_off_q   <= row_off_d;
      col_q       <= col_d;
      pix_valid_q <= pix_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && func == FUNC_PIXEL) begin
      pix_q.row_x   <= row_x_q;
      pix_q.row_y   <= row_y_q;
      pix_q.col_x   <= col_x_q;
      pix_q.col_y   <= col_y_q;
      pix_q.row_off <= row_off_q;
      pix_q.col     <= col_q;
    end
  end

  assign pix_valid_o = pix_valid_q;
  assign pix_o       = pix_q;

endmodule

### sv/rba_addr.sv
// Address computation and result register with the 2x2 write sequencer.
module rba_addr (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rba_pkg::cfg_t                    cfg_i,
  input  logic                             pix_valid_i,
  input  rba_pkg::pix_t                    pix_i,
  output logic                             adv_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [rba_pkg::OFS_W-1:0] src_dx_o,
  output logic signed [rba_pkg::OFS_W-1:0] src_dy_o,
  output logic [rba_pkg::ADDR_W-1:0]       src_address_o,
  output logic [rba_pkg::ADDR_W-1:0]       dst_address_o,
  output logic                             last_o
);
  import rba_pkg::*;

  localparam int DX_W = OFS_W + 1;

  logic signed [OFS_W-1:0]  fx_r, fx_c, fy_r, fy_c;
  logic signed [DX_W-1:0]   dx, dy;
  logic signed [ADDR_W-1:0] dx32, dy32, stride32, prod;
  logic [ADDR_W-1:0]        dx_sh, saddr;
  logic [ADDR_W-1:0]        col32, plain, dbase;
  logic [STRIDE_W-1:0]      pix, line;

  logic                     valid_q, valid_d;
  logic                     dbl_q;
  logic [1:0]               k_q, k_d;
  logic signed [OFS_W-1:0]  dx_q, dy_q;
  logic [ADDR_W-1:0]        saddr_q, base_q, dst_q, dst_d;
  logic [STRIDE_W-1:0]      pix_q, line_q;
  logic                     xfer, last, load, step;

  // Row and column terms are floored on their own, then summed.
  assign fx_r = OFS_W'(pix_i.row_x >>> FRAC_BITS);
  assign fx_c = OFS_W'(pix_i.col_x >>> FRAC_BITS);
  assign fy_r = OFS_W'(pix_i.row_y >>> FRAC_BITS);
  assign fy_c = OFS_W'(pix_i.col_y >>> FRAC_BITS);
  assign dx   = DX_W'(fx_r) + DX_W'(fx_c);
  assign dy   = DX_W'(fy_r) + DX_W'(fy_c);

  assign dx32     = ADDR_W'(dx);
  assign dy32     = ADDR_W'(dy);
  assign stride32 = $signed(ADDR_W'(cfg_i.src_stride));
  assign prod     = dy32 * stride32;
  assign dx_sh    = cfg_i.mode[0] ? (dx32 << 2) : (dx32 << 1);
  assign saddr    = cfg_i.src_base + dx_sh + prod;

  assign col32 = ADDR_W'(pix_i.col);
  assign plain = pix_i.row_off + (cfg_i.mode[0] ? (col32 << 2) : (col32 << 1));
  assign dbase = pix_i.row_off + (cfg_i.mode[0] ? (col32 << 3) : (col32 << 2));
  assign pix   = cfg_i.mode[0] ? STRIDE_W'(4) : STRIDE_W'(2);
  assign line  = cfg_i.dst_stride & ~(pix - STRIDE_W'(1));

  assign xfer  = valid_q & ~out_stall_i;
  assign last  = ~dbl_q | (k_q == 2'd3);
  assign adv_o = ~valid_q | (xfer & last);
  assign load  = pix_valid_i & adv_o;
  assign step  = xfer & ~last;

  always_comb begin
    k_d = k_q + 2'd1;
    case (k_d)
      2'd1:    dst_d = base_q + ADDR_W'(pix_q);
      2'd2:    dst_d = base_q + ADDR_W'(line_q);
      default: dst_d = base_q + ADDR_W'(line_q) + ADDR_W'(pix_q);
    endcase
  end

  always_comb begin
    if (load) valid_d = 1'b1;
    else if (xfer && last) valid_d = 1'b0;
    else valid_d = valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      k_q     <= '0;
      dbl_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (load) begin
        k_q   <= '0;
        dbl_q <= cfg_i.mode[1];
      end else if (step) begin
        k_q <= k_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dx_q    <= dx[OFS_W-1:0];
      dy_q    <= dy[OFS_W-1:0];
      saddr_q <= saddr;
      base_q  <= dbase;
      pix_q   <= pix;
      line_q  <= line;
      dst_q   <= cfg_i.mode[1] ? dbase : plain;
    end else if (step) begin
      dst_q <= dst_d;
    end
  end

  assign out_valid_o   = valid_q;
  assign src_dx_o      = dx_q;
  assign src_dy_o      = dy_q;
  assign src_address_o = saddr_q;
  assign dst_address_o = dst_q;
  assign last_o        = valid_q & last;

`ifndef NO_ASSERTIONS
  a_load_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_valid_i && !valid_q) |=> valid_q)
    else $error("pending pixel did not reach the result register");
  a_plain_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !dbl_q) |-> last_o)
    else $error("plain pixel result without last");
  a_more_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && !last) |=> (valid_q && $past(k_q) + 2'd1 == k_q))
    else $error("doubled pixel sequence broken");
  a_no_early_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && out_stall_i) |=> ($stable(saddr_q) && $stable(dst_q)))
    else $error("result changed while stalled");
`endif

endmodule

### sv/rotated_blit_address_generator.sv
// Top level of the rotated blit address generator.
// Accepts one command per clock while in_stall_o is low: clear frame, begin
// span, next pixel or end row. Each next-pixel command yields one result
// (source offsets, source byte address, destination byte offset) through the
// pixel register and then the result register; with 2x2 doubling on, the
// output sequencer issues four results and the next pixel waits in the pixel
// register, stalling the input, until the last is taken. Clear, begin span
// and end row yield no result. Source address needs one 15x17-bit multiply
// between the pixel register and the result register. Registers must be
// written through the APB-style port only while the block idles; the block itself does not enforce this.
module rotated_blit_address_generator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rba_pkg::PADDR_W-1:0]      paddr,
  input  logic [rba_pkg::PDATA_W-1:0]      pwdata,
  output logic [rba_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [rba_pkg::FUNC_W-1:0]       func_i,
  input  logic [rba_pkg::IN_COL_W-1:0]     column_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [rba_pkg::OFS_W-1:0] src_dx_o,
  output logic signed [rba_pkg::OFS_W-1:0] src_dy_o,
  output logic [rba_pkg::ADDR_W-1:0]       src_address_o,
  output logic [rba_pkg::ADDR_W-1:0]       dst_address_o,
  output logic                             last_o
);
  import rba_pkg::*;

  cfg_t cfg;
  pix_t pix;
  logic pix_valid, adv, accept;

  assign in_stall_o = pix_valid & ~adv;
  assign accept     = in_valid_i & ~in_stall_o;

  rba_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rba_dda u_dda (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .accept_i    (accept),
    .func_i      (func_i),
    .column_i    (column_i),
    .adv_i       (adv),
    .pix_valid_o (pix_valid),
    .pix_o       (pix)
  );

  rba_addr u_addr (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .pix_valid_i   (pix_valid),
    .pix_i         (pix),
    .adv_o         (adv),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .src_dx_o      (src_dx_o),
    .src_dy_o      (src_dy_o),
    .src_address_o (src_address_o),
    .dst_address_o (dst_address_o),
    .last_o        (last_o)
  );

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the rotated blit address generator.
module tb;
  import rba_pkg::*;

  localparam int DRAIN_CYCLES = 8;     // result pipe is two deep; margin for doubling
  localparam int STUCK_LIMIT  = 1000;  // cycles without any transfer before giving up
  localparam int LONG_ROW     = 90;    // pixels in the stretch without idling

  typedef struct packed {
    logic [OFS_W-1:0]  src_dx;
    logic [OFS_W-1:0]  src_dy;
    logic [ADDR_W-1:0] src_address;
    logic [ADDR_W-1:0] dst_address;
    logic              last;
  } pix_write_t;

  typedef struct {
    bit          is_reg;
    reg_idx_e    idx;
    int          value;
    func_e       op;
    logic [11:0] column;
    bit          typed;
    pix_write_t  want;
  } row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [FUNC_W-1:0]   func_i;
  logic [IN_COL_W-1:0] column_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic signed [OFS_W-1:0] src_dx_o;
  logic signed [OFS_W-1:0] src_dy_o;
  logic [ADDR_W-1:0]   src_address_o;
  logic [ADDR_W-1:0]   dst_address_o;
  logic                last_o;

  rotated_blit_address_generator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .column_i      (column_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .src_dx_o      (src_dx_o),
    .src_dy_o      (src_dy_o),
    .src_address_o (src_address_o),
    .dst_address_o (dst_address_o),
    .last_o        (last_o)
  );

  // Shadow of the register file and of the walker state.
  cfg_t              cfg;
  logic [ACC_W-1:0]  walk_rx, walk_ry, walk_cx, walk_cy;
  logic [ADDR_W-1:0] walk_row_ofs;
  logic [COL_W-1:0]  walk_col;

  pix_write_t pending_writes[$];
  bit         steady;          // no idling on either side while set
  int         mismatches;
  int         writes_seen;
  int         cmds_sent;
  int         reg_writes;
  int         stuck;

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Advances the walker by one command; returns the number of writes it yields.
  function automatic int dda_advance(func_e f, logic [11:0] c, output pix_write_t w [4]);
    logic signed [31:0] dx, dy;
    logic [31:0]        saddr, prod, pix, line, base_ofs;
    logic [31:0]        dst [4];
    int                 psh, n;
    bit                 dbl;
    psh = cfg.mode[0] ? 2 : 1;
    dbl = cfg.mode[1];
    n = 0;
    case (f)
      FUNC_CLEAR: begin
        walk_rx = '0; walk_ry = '0; walk_cx = '0; walk_cy = '0;
        walk_row_ofs = '0; walk_col = '0;
      end
      FUNC_SPAN: begin
        prod = {20'd0, c} * {{20{cfg.step_hx[11]}}, cfg.step_hx};
        walk_cx = prod[ACC_W-1:0];
        prod = {20'd0, c} * {{20{cfg.step_hy[11]}}, cfg.step_hy};
        walk_cy = prod[ACC_W-1:0];
        walk_col = {1'b0, c};
      end
      FUNC_EOR: begin
        walk_rx = walk_rx + {{12{cfg.step_vx[11]}}, cfg.step_vx};
        walk_ry = walk_ry + {{12{cfg.step_vy[11]}}, cfg.step_vy};
        walk_row_ofs = walk_row_ofs + (dbl ? {15'd0, cfg.dst_stride, 1'b0}
                                           : {16'd0, cfg.dst_stride});
        walk_cx = '0; walk_cy = '0;
        walk_col = '0;
      end
      default: begin
        // row and column terms are floored separately
        dx = ($signed(walk_rx) >>> FRAC_BITS) + ($signed(walk_cx) >>> FRAC_BITS);
        dy = ($signed(walk_ry) >>> FRAC_BITS) + ($signed(walk_cy) >>> FRAC_BITS);
        saddr = cfg.src_base + (dx << psh) + dy * {16'd0, cfg.src_stride};
        if (dbl) begin
          pix = 32'd1 << psh;
          line = {16'd0, cfg.dst_stride} & ~(pix - 32'd1);
          base_ofs = walk_row_ofs + ({19'd0, walk_col} << (psh + 1));
          dst[0] = base_ofs;
          dst[1] = base_ofs + pix;
          dst[2] = base_ofs + line;
          dst[3] = base_ofs + line + pix;
          n = 4;
        end else begin
          dst[0] = walk_row_ofs + ({19'd0, walk_col} << psh);
          n = 1;
        end
        for (int k = 0; k < n; k++) begin
          w[k].src_dx      = dx[OFS_W-1:0];
          w[k].src_dy      = dy[OFS_W-1:0];
          w[k].src_address = saddr;
          w[k].dst_address = dst[k];
          w[k].last        = (k == n - 1);
        end
        walk_cx = walk_cx + {{12{cfg.step_hx[11]}}, cfg.step_hx};
        walk_cy = walk_cy + {{12{cfg.step_hy[11]}}, cfg.step_hy};
        walk_col = walk_col + 1'b1;
      end
    endcase
    return n;
  endfunction

  function automatic row_t cmd(func_e f, int c = 0);
    row_t r;
    r = '{is_reg: 1'b0, idx: REG_STEP_HX, value: 0, op: f, column: c[11:0],
          typed: 1'b0, want: '0};
    return r;
  endfunction

  // plain-mode pixel whose single write is known up front
  function automatic row_t px_at(int dx, int dy, int sa, int da);
    row_t r;
    r = cmd(FUNC_PIXEL);
    r.typed = 1'b1;
    r.want = '{src_dx: dx[OFS_W-1:0], src_dy: dy[OFS_W-1:0], src_address: sa,
               dst_address: da, last: 1'b1};
    return r;
  endfunction

  function automatic row_t wr(reg_idx_e idx, int v);
    row_t r;
    r = '{is_reg: 1'b1, idx: idx, value: v, op: FUNC_CLEAR, column: '0,
          typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic int pick_step();
    case ($urandom_range(7))
      0: return -1024;
      1: return 1024;
      2: return 0;
      default: return int'($urandom_range(2048)) - 1024;
    endcase
  endfunction

  // Called right after a rising edge; returns right after the accepting edge.
  task automatic send_cmd(func_e f, logic [11:0] c, bit typed = 1'b0,
                          pix_write_t want = '0);
    pix_write_t w [4];
    int         n;
    while (!steady && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    column_i   <= c;
    forever begin
      @(negedge clk_i);
      if (!in_stall_o) break;
    end
    @(posedge clk_i);
    cmds_sent++;
    n = dda_advance(f, c, w);
    if (typed) pending_writes.push_back(want);
    else for (int k = 0; k < n; k++) pending_writes.push_back(w[k]);
  endtask

  // Lets the block run dry before a register write or the end of the run.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(reg_idx_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_writes++;
    case (idx)
      REG_STEP_HX:    cfg.step_hx    = value[STEP_W-1:0];
      REG_STEP_HY:    cfg.step_hy    = value[STEP_W-1:0];
      REG_STEP_VX:    cfg.step_vx    = value[STEP_W-1:0];
      REG_STEP_VY:    cfg.step_vy    = value[STEP_W-1:0];
      REG_SRC_BASE:   cfg.src_base   = value;
      REG_SRC_STRIDE: cfg.src_stride = value[STRIDE_W-1:0];
      REG_DST_STRIDE: cfg.dst_stride = value[STRIDE_W-1:0];
      REG_MODE:       cfg.mode       = value[MODE_W-1:0];
      default: ;
    endcase
  endtask

  // Receiver side: random stall, drawn at each rising edge.
  always @(posedge clk_i) out_stall_i <= !steady && ($urandom_range(99) < 6);

  // Outputs are sampled mid-cycle, where they are stable for the next edge.
  always @(negedge clk_i) begin
    pix_write_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        writes_seen++;
        if (pending_writes.size() == 0) begin
          $error("unexpected write: dst_address %h", dst_address_o);
          mismatches++;
        end else begin
          want = pending_writes.pop_front();
          if (src_dx_o !== want.src_dx) begin
            $error("src_dx: expected %0d, got %0d", $signed(want.src_dx), src_dx_o);
            mismatches++;
          end
          if (src_dy_o !== want.src_dy) begin
            $error("src_dy: expected %0d, got %0d", $signed(want.src_dy), src_dy_o);
            mismatches++;
          end
          if (src_address_o !== want.src_address) begin
            $error("src_address: expected %h, got %h", want.src_address, src_address_o);
            mismatches++;
          end
          if (dst_address_o !== want.dst_address) begin
            $error("dst_address: expected %h, got %h", want.dst_address, dst_address_o);
            mismatches++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last_o);
            mismatches++;
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck = 0;
      else stuck++;
      if (stuck >= STUCK_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", stuck);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    row_t plan[$];
    int   ph, k, r;

    rst_ni      <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_valid_i  <= 1'b0;
    func_i      <= FUNC_CLEAR;
    column_i    <= '0;
    steady      = 1'b0;
    mismatches  = 0;
    writes_seen = 0;
    cmds_sent   = 0;
    reg_writes  = 0;
    stuck       = 0;
    cfg = '{step_hx: 12'sd1024, step_vy: 12'sd1024, default: '0};
    walk_rx = '0; walk_ry = '0; walk_cx = '0; walk_cy = '0;
    walk_row_ofs = '0; walk_col = '0;

    // Reset values first, then register extremes, then each pixel mode.
    plan = '{
      px_at(0, 0, 0, 0),
      px_at(1, 0, 2, 2),
      cmd(FUNC_EOR),
      px_at(0, 1, 0, 0),
      cmd(FUNC_SPAN, 4095),
      px_at(4095, 1, 8190, 8190),
      px_at(4096, 1, 8192, 8192),
      cmd(FUNC_CLEAR),
      px_at(0, 0, 0, 0),
      wr(REG_STEP_HX, -1024),
      wr(REG_STEP_HY, 1024),
      wr(REG_STEP_VX, -1024),
      wr(REG_STEP_VY, -1024),
      wr(REG_SRC_BASE, -1),
      wr(REG_SRC_STRIDE, 65535),
      wr(REG_DST_STRIDE, 65535),
      wr(REG_MODE, 3),
      cmd(FUNC_PIXEL),
      cmd(FUNC_SPAN, 4095),
      cmd(FUNC_PIXEL),
      cmd(FUNC_PIXEL),
      cmd(FUNC_EOR),
      cmd(FUNC_PIXEL),
      cmd(FUNC_EOR),
      cmd(FUNC_SPAN, 0),
      cmd(FUNC_PIXEL),
      wr(REG_MODE, 1),
      cmd(FUNC_PIXEL),
      cmd(FUNC_EOR),
      cmd(FUNC_PIXEL),
      wr(REG_MODE, 2),
      wr(REG_DST_STRIDE, 7),
      cmd(FUNC_PIXEL),
      cmd(FUNC_EOR),
      cmd(FUNC_PIXEL),
      cmd(FUNC_CLEAR)
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        drain();
        reg_write(plan[i].idx, plan[i].value);
      end else begin
        send_cmd(plan[i].op, plan[i].column, plan[i].typed, plan[i].want);
      end
    end

    // Random phases: one per pixel mode plus one more, fresh registers each.
    for (ph = 0; ph < 5; ph++) begin
      drain();
      reg_write(REG_STEP_HX, pick_step());
      reg_write(REG_STEP_HY, pick_step());
      reg_write(REG_STEP_VX, pick_step());
      reg_write(REG_STEP_VY, pick_step());
      reg_write(REG_SRC_BASE, ($urandom_range(4) == 0) ? 32'hFFFF_FFFF : $urandom());
      reg_write(REG_SRC_STRIDE, ($urandom_range(1) == 0) ? $urandom_range(8192)
                                                         : $urandom_range(65535));
      reg_write(REG_DST_STRIDE, ($urandom_range(1) == 0) ? $urandom_range(8192)
                                                         : $urandom_range(65535));
      reg_write(REG_MODE, (ph < 4) ? ph : $urandom_range(3));
      for (k = 0; k < 60; k++) begin
        r = $urandom_range(99);
        if (r < 3) send_cmd(FUNC_CLEAR, 12'($urandom()));
        else if (r < 15) send_cmd(FUNC_SPAN, ($urandom_range(9) == 0) ? 12'hFFF
                                                                      : 12'($urandom()));
        else if (r < 30) send_cmd(FUNC_EOR, 12'($urandom()));
        else send_cmd(FUNC_PIXEL, 12'($urandom()));
      end
    end

    // One long row from the last column, back to back with no idling on
    // either side.
    drain();
    reg_write(REG_MODE, 0);
    reg_write(REG_STEP_HX, 1024);
    reg_write(REG_STEP_HY, -1024);
    reg_write(REG_STEP_VX, 1024);
    reg_write(REG_STEP_VY, -1024);
    steady = 1'b1;
    send_cmd(FUNC_CLEAR, 12'd0);
    repeat (3) send_cmd(FUNC_EOR, 12'($urandom()));
    send_cmd(FUNC_SPAN, 12'hFFF);
    repeat (LONG_ROW) send_cmd(FUNC_PIXEL, 12'($urandom()));
    steady = 1'b0;

    drain();
    $display("Sent %0d commands and checked %0d pixel writes over %0d register writes,",
             cmds_sent, writes_seen, reg_writes);
    $display("covering all four pixel modes and a long row with no idling.");
    if (mismatches == 0 && pending_writes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
